// File: sv/png_scanline_unfilter_assert.svh
// Assertion macros used by the scanline unfilter RTL.
// Each macro expects the signals clk and arst_n in the module that uses it.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/png_unf_pkg.sv
package png_unf_pkg;

	localparam int DEF_MAX_LINE_BYTES  = 4096;
	localparam int DEF_MAX_PIXEL_BYTES = 8;

	localparam int LINE_BYTES_W  = 13;
	localparam int PIXEL_BYTES_W = 4;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_INDEX_W   = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 1'd1;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       image_start;
	} psu_in_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       row_end;
		logic       filter_error;
	} psu_out_t;

	function automatic logic [10:0] abs11(input logic signed [10:0] v);
		abs11 = v[10] ? 11'(-v) : 11'(v);
	endfunction

	// Paeth predictor with full-precision distances.
	function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [10:0] sa, sb, sc;
		logic [10:0] pa, pb, pc;
		sa = signed'({3'b000, a});
		sb = signed'({3'b000, b});
		sc = signed'({3'b000, c});
		pa = abs11(sb - sc);
		pb = abs11(sa - sc);
		pc = abs11(sa + sb - (sc <<< 1));
		if (pa <= pb && pa <= pc)
			paeth_pred = a;
		else if (pb <= pc)
			paeth_pred = b;
		else
			paeth_pred = c;
	endfunction

endpackage

// File: sv/png_scanline_unfilter.sv
// PNG scanline reconstruction, one filtered byte per word.
// Input channel (in_valid, in_stall, in_data): a stream of scanlines, each a
// filter type word followed by line_bytes filtered words. image_start marks the
// filter word of the first row of an image, whose upper neighbours read as zero.
// Output channel (out_valid, out_stall, out_data): one reconstructed word per
// filtered data word, none for a filter word; row_end marks the last word of a
// row and filter_error marks every word of a row whose filter type was above 4.
// Configuration (cfg_we, cfg_index, cfg_data) sets line_bytes and pixel_bytes; the user
// must write it only while the block is idle, and the block itself does not enforce this.
// Throughput is one word per cycle while the receiver does not stall. Two register
// stages: the input stage takes a word and reads the previous row from the line
// store, then the predictor is added and the result loaded into the output register.
// When the receiver stalls, the output register holds and the input stage keeps
// taking words until it is full itself, then in_stall rises.
// Reset empties both stages, clears the row tracking and sets both registers
// to 1; the line store needs no clearing, a fill count marks its written part.
module png_scanline_unfilter
	import png_unf_pkg::*;
#(
	parameter int MAX_LINE_BYTES  = DEF_MAX_LINE_BYTES,
	parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  psu_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output psu_out_t               out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IW = $clog2(MAX_LINE_BYTES);
	localparam int LW = $clog2(MAX_LINE_BYTES + 1);
	localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	logic [LINE_BYTES_W-1:0]  line_q;
	logic [PIXEL_BYTES_W-1:0] pix_q;

	logic [LW-1:0] pos_q;
	logic          first_q;
	filter_t       filter_q;
	logic          bad_q;
	logic [LW-1:0] fill_q;

	logic [7:0] line_mem [MAX_LINE_BYTES];
	logic [7:0] left_q [MAX_PIXEL_BYTES];
	logic [7:0] upleft_q [MAX_PIXEL_BYTES];

	logic          v_s1;
	logic [7:0]    x_s1;
	logic [IW-1:0] i_s1;
	filter_t       filter_s1;
	logic          bad_s1;
	logic          last_s1;
	logic          bzero_s1;
	logic          usea_s1;
	logic [7:0]    rd_s1;

	logic     out_v_q;
	psu_out_t out_q;

	logic [31:0]   len32;
	logic [31:0]   bpp32;
	logic [PW-1:0] bidx;
	logic          accept;
	logic          is_filter;
	logic          data_acc;
	logic [IW-1:0] idx;
	logic          last;
	logic          s1_adv;
	logic [7:0]    a_val, b_val, c_val, pred, res;
	logic [8:0]    avg_sum;

	always_comb begin
		if (line_q == '0)
			len32 = 32'd1;
		else if (32'(line_q) > 32'(MAX_LINE_BYTES))
			len32 = 32'(MAX_LINE_BYTES);
		else
			len32 = 32'(line_q);
		if (pix_q == '0)
			bpp32 = 32'd1;
		else if (32'(pix_q) > 32'(MAX_PIXEL_BYTES))
			bpp32 = 32'(MAX_PIXEL_BYTES);
		else
			bpp32 = 32'(pix_q);
	end

	assign bidx = PW'(bpp32 - 32'd1);

	// An image start forces the word to be taken as a filter type.
	assign s1_adv    = v_s1 && (!out_v_q || !out_stall);
	assign in_stall  = v_s1 && !s1_adv;
	assign accept    = in_valid && !in_stall;
	assign is_filter = in_data.image_start || (pos_q == '0);
	assign data_acc  = accept && !is_filter;
	assign idx       = IW'(pos_q - LW'(1));
	assign last      = 32'(pos_q) >= len32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_BYTES_W'(1);
			pix_q  <= PIXEL_BYTES_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_BYTES:  line_q <= cfg_data[LINE_BYTES_W-1:0];
				REG_PIXEL_BYTES: pix_q  <= cfg_data[PIXEL_BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			first_q  <= 1'b1;
			filter_q <= FILT_NONE;
			bad_q    <= 1'b0;
		end else if (accept) begin
			if (is_filter) begin
				if (in_data.data_byte > 8'd4) begin
					filter_q <= FILT_NONE;
					bad_q    <= 1'b1;
				end else begin
					filter_q <= filter_t'(in_data.data_byte[2:0]);
					bad_q    <= 1'b0;
				end
				pos_q <= LW'(1);
				if (in_data.image_start)
					first_q <= 1'b1;
			end else if (last) begin
				pos_q   <= '0;
				first_q <= 1'b0;
			end else begin
				pos_q <= pos_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (accept || s1_adv)
			v_s1 <= data_acc;
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			x_s1      <= in_data.data_byte;
			i_s1      <= idx;
			filter_s1 <= filter_q;
			bad_s1    <= bad_q;
			last_s1   <= last;
			bzero_s1  <= first_q || (LW'(idx) >= fill_q);
			usea_s1   <= 32'(idx) >= bpp32;
		end
	end

	// Line store: read for the word entering, written as the word leaves. A row
	// always begins at index zero, so the written entries form a prefix.
	always_ff @(posedge clk) begin
		if (data_acc)
			rd_s1 <= line_mem[idx];
		if (s1_adv)
			line_mem[i_s1] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (s1_adv && LW'(i_s1) >= fill_q)
			fill_q <= LW'(i_s1) + LW'(1);
	end

	assign a_val   = usea_s1 ? left_q[bidx] : 8'd0;
	assign c_val   = usea_s1 ? upleft_q[bidx] : 8'd0;
	assign b_val   = bzero_s1 ? 8'd0 : rd_s1;
	assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

	always_comb begin
		case (filter_s1)
			FILT_SUB:   pred = a_val;
			FILT_UP:    pred = b_val;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth_pred(a_val, b_val, c_val);
			default:    pred = 8'd0;
		endcase
	end

	assign res = x_s1 + pred;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int j = MAX_PIXEL_BYTES - 1; j > 0; j--) begin
				left_q[j]   <= left_q[j-1];
				upleft_q[j] <= upleft_q[j-1];
			end
			left_q[0]   <= res;
			upleft_q[0] <= b_val;
			out_q.pixel_byte   <= res;
			out_q.row_end      <= last_s1;
			out_q.filter_error <= bad_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (s1_adv)
			out_v_q <= 1'b1;
		else if (!out_stall)
			out_v_q <= 1'b0;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`include "png_scanline_unfilter_assert.svh"

	`PSU_ASSERT_NEXT(a_data_enters_s1, data_acc, v_s1, "data word did not reach the add stage")
	`PSU_ASSERT_NEXT(a_filter_sets_pos, accept && is_filter, pos_q == LW'(1),
		"filter word did not start a row")
	`PSU_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill_q) <= 32'(MAX_LINE_BYTES),
		"line store fill count out of range")
	`PSU_ASSERT_NOW(a_pos_bound, 1'b1, 32'(pos_q) <= 32'(MAX_LINE_BYTES),
		"row position out of range")
	`PSU_ASSERT_NEXT(a_last_clears_pos, data_acc && last, pos_q == '0,
		"last word of a row did not rewind the position")

endmodule

// File: bench/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps

module tb_png_scanline_unfilter;
	import png_unf_pkg::*;

	localparam int MAX_LEN   = DEF_MAX_LINE_BYTES;
	localparam int MAX_PIX   = DEF_MAX_PIXEL_BYTES;
	localparam int WORD_GOAL = 1850;
	localparam int PLAN_ROWS = 25;

	typedef struct packed {
		logic                    set_cfg;
		logic [LINE_BYTES_W-1:0] len_val;
		logic [PIXEL_BYTES_W-1:0] pix_val;
		psu_in_t                 word;
		logic                    typed;
		psu_out_t                want;
	} plan_row_t;

	// Directed rows: extremes, every filter type, invalid types, image starts,
	// a line length lowered mid-row and out-of-range register values.
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{1'b0, 13'd0, 4'd0, '{8'h00, 1'b1}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h05, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1}},
		'{1'b0, 13'd0, 4'd0, '{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h80, 1'b0}, 1'b1, '{8'h80, 1'b1, 1'b1}},
		'{1'b0, 13'd0, 4'd0, '{8'h02, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h80, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{1'b1, 13'd3, 4'd1, '{8'h04, 1'b1}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h10, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'hF0, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h7F, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h03, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h01, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'hAA, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h01, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h55, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b1, 13'd2, 4'd8, '{8'h66, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h02, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h01, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h02, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b1, 13'd0, 4'd0, '{8'h04, 1'b1}, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{1'b0, 13'd0, 4'd0, '{8'h9C, 1'b0}, 1'b1, '{8'h9C, 1'b1, 1'b0}}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	psu_in_t                in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	psu_out_t               out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_LINE_BYTES;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	png_scanline_unfilter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the block's registers and row state.
	logic [LINE_BYTES_W-1:0]  len_reg = 13'd1;
	logic [PIXEL_BYTES_W-1:0] pix_reg = 4'd1;
	logic [7:0] prev_line [MAX_LEN];
	logic [7:0] left_bytes [MAX_PIX];
	logic [7:0] diag_bytes [MAX_PIX];
	filter_t    row_filt = FILT_NONE;
	int         row_pos = 0;
	bit         top_row = 1'b1;
	bit         bad_type = 1'b0;

	psu_out_t pending_pixels [$];
	int       mismatch_count = 0;
	int       word_count = 0;
	bit       calm = 1'b0;

	initial begin
		for (int k = 0; k < MAX_LEN; k++)
			prev_line[k] = 8'h00;
		for (int k = 0; k < MAX_PIX; k++) begin
			left_bytes[k] = 8'h00;
			diag_bytes[k] = 8'h00;
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int eff_len(input int raw);
		if (raw == 0)
			return 1;
		return (raw > MAX_LEN) ? MAX_LEN : raw;
	endfunction

	function automatic int paeth_pick(input int a, input int b, input int c);
		int pa, pb, pc;
		pa = (b > c) ? b - c : c - b;
		pb = (a > c) ? a - c : c - a;
		pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
		if (pa <= pb && pa <= pc)
			return a;
		if (pb <= pc)
			return b;
		return c;
	endfunction

	// Advances the shadow state by one accepted word and queues its pixel if it is a data word.
	function automatic void predict_pixel(input psu_in_t w);
		int len, pix, idx, a, b, c, guess;
		logic [7:0] res;
		psu_out_t o;
		len = eff_len(len_reg);
		pix = (pix_reg == 0) ? 1 : ((pix_reg > MAX_PIX) ? MAX_PIX : pix_reg);
		if (w.image_start) begin
			row_pos = 0;
			top_row = 1'b1;
		end
		if (row_pos == 0) begin
			if (w.data_byte > 8'd4) begin
				row_filt = FILT_NONE;
				bad_type = 1'b1;
			end else begin
				row_filt = filter_t'(w.data_byte[2:0]);
				bad_type = 1'b0;
			end
			for (int k = 0; k < MAX_PIX; k++) begin
				left_bytes[k] = 8'h00;
				diag_bytes[k] = 8'h00;
			end
			row_pos = 1;
			return;
		end
		idx = row_pos - 1;
		if (idx >= MAX_LEN)
			idx = MAX_LEN - 1;
		b = top_row ? 0 : int'(prev_line[idx]);
		a = (idx >= pix) ? int'(left_bytes[pix-1]) : 0;
		c = (idx >= pix) ? int'(diag_bytes[pix-1]) : 0;
		case (row_filt)
			FILT_SUB:   guess = a;
			FILT_UP:    guess = b;
			FILT_AVG:   guess = (a + b) / 2;
			FILT_PAETH: guess = paeth_pick(a, b, c);
			default:    guess = 0;
		endcase
		res = 8'(int'(w.data_byte) + guess);
		for (int k = MAX_PIX - 1; k > 0; k--) begin
			left_bytes[k] = left_bytes[k-1];
			diag_bytes[k] = diag_bytes[k-1];
		end
		left_bytes[0] = res;
		diag_bytes[0] = 8'(b);
		prev_line[idx] = res;
		o.pixel_byte = res;
		o.row_end = (idx + 1 >= len);
		o.filter_error = bad_type;
		pending_pixels.push_back(o);
		if (o.row_end) begin
			row_pos = 0;
			top_row = 1'b0;
		end else begin
			row_pos = idx + 2;
		end
	endfunction

	task automatic send_word(input psu_in_t w);
		while (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_pixel(w);
		word_count++;
	endtask

	// Drains the pipe; filter words leave no result, so it waits on after the queue empties.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LINE_BYTES)
			len_reg = LINE_BYTES_W'(val);
		else
			pix_reg = PIXEL_BYTES_W'(val);
	endtask

	task automatic set_config(input int len_raw, input int pix_raw);
		wait_idle();
		write_reg(REG_LINE_BYTES, len_raw);
		write_reg(REG_PIXEL_BYTES, pix_raw);
	endtask

	always @(posedge clk) begin
		psu_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, out_data);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.pixel_byte !== want.pixel_byte) begin
					$display("%0t: pixel_byte expected %h actual %h", $time,
						want.pixel_byte, out_data.pixel_byte);
					mismatch_count++;
				end
				if (out_data.row_end !== want.row_end) begin
					$display("%0t: row_end expected %b actual %b", $time,
						want.row_end, out_data.row_end);
					mismatch_count++;
				end
				if (out_data.filter_error !== want.filter_error) begin
					$display("%0t: filter_error expected %b actual %b", $time,
						want.filter_error, out_data.filter_error);
					mismatch_count++;
				end
			end
		end
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
	end

	initial begin
		psu_in_t w;
		int phase, len_raw, pix_raw, len, span, images, rows, pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < PLAN_ROWS; n++) begin
			if (PLAN[n].set_cfg)
				set_config(PLAN[n].len_val, PLAN[n].pix_val);
			send_word(PLAN[n].word);
			if (PLAN[n].typed) begin
				void'(pending_pixels.pop_back());
				pending_pixels.push_back(PLAN[n].want);
			end
		end

		phase = 0;
		while (word_count < WORD_GOAL + PLAN_ROWS) begin
			if (phase == 0) begin
				// Line length and pixel size both saturate here; the long row is
				// cut short by the image start of the next group.
				len_raw = 8191;
				pix_raw = 15;
			end else begin
				pick = $urandom_range(99);
				if (pick < 10)
					len_raw = 0;
				else if (pick < 25)
					len_raw = $urandom_range(17, 64);
				else
					len_raw = $urandom_range(1, 16);
				pix_raw = $urandom_range(0, 15);
			end
			set_config(len_raw, pix_raw);
			calm = (phase == 0);
			len = eff_len(len_raw);
			span = (len > 64) ? 600 : len;
			images = (len > 64) ? 1 : $urandom_range(1, 3);
			for (int img = 0; img < images; img++) begin
				rows = (len > 64) ? 1 : $urandom_range(1, 6);
				for (int r = 0; r < rows; r++) begin
					w.data_byte = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 4))
						: 8'($urandom_range(5, 255));
					w.image_start = (r == 0);
					send_word(w);
					for (int j = 0; j < span; j++) begin
						w.data_byte = 8'($urandom);
						// Now and then a stray image start breaks the row.
						w.image_start = ($urandom_range(99) < 3);
						send_word(w);
					end
				end
			end
			phase++;
		end
		calm = 1'b0;

		wait_idle();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
